// ----- sv/mcg_pkg.sv -----
`default_nettype none
package mcg_pkg;

  localparam int COORD_BITS  = 10;
  localparam int OFS_BITS    = 12;
  localparam int DEC_BITS    = 16;
  localparam int PT_BITS     = 12;
  localparam int OCT_BITS    = 3;
  localparam int SQ_BITS     = 2 * COORD_BITS;
  localparam int ROOT_BITS   = 2 * COORD_BITS + 2;
  localparam int ROOT_ITERS  = COORD_BITS + 1;
  localparam int ITER_BITS   = $clog2(ROOT_ITERS + 1);
  localparam int RADIUS_MAX  = 2 ** (OFS_BITS - 1) - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [OFS_BITS-1:0] ofs_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;
  typedef logic signed [PT_BITS-1:0]  pt_t;
  typedef logic [OCT_BITS-1:0]        oct_t;

  localparam dec_t DEC_INIT     = dec_t'(3);
  localparam dec_t DEC_INC_DIAG = dec_t'(10);
  localparam dec_t DEC_INC_AXIS = dec_t'(6);
  localparam oct_t LAST_OCTANT  = oct_t'(7);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef struct packed {
    op_e    op;
    coord_t cx;
    coord_t cy;
    ofs_t   radius;
  } cmd_t;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_SQUARE,
    FE_SUM,
    FE_ROOT,
    FE_ROUND,
    FE_PUSH
  } front_state_e;

  typedef enum logic {
    BE_IDLE,
    BE_EMIT
  } back_state_e;

  // zero-extend or wrap a coordinate to the point width
  function automatic logic [PT_BITS-1:0] to_pt(coord_t c);
    logic [PT_BITS+COORD_BITS-1:0] w;
    w = {{PT_BITS{1'b0}}, c};
    return w[PT_BITS-1:0];
  endfunction

  function automatic dec_t ofs_to_dec(ofs_t v);
    return {{(DEC_BITS-OFS_BITS){v[OFS_BITS-1]}}, v};
  endfunction

endpackage
`default_nettype wire

// ----- sv/mcg_in_if.sv -----
`default_nettype none
interface mcg_in_if;
  import mcg_pkg::*;

  logic   valid;
  logic   ready;
  logic   operation;
  coord_t center_x;
  coord_t center_y;
  coord_t rim_x;
  coord_t rim_y;

  modport source (output valid, operation, center_x, center_y, rim_x, rim_y, input ready);
  modport sink   (input valid, operation, center_x, center_y, rim_x, rim_y, output ready);
endinterface
`default_nettype wire

// ----- sv/mcg_out_if.sv -----
`default_nettype none
interface mcg_out_if;
  import mcg_pkg::*;

  logic valid;
  logic ready;
  pt_t  point_x;
  pt_t  point_y;
  oct_t octant;
  logic last;

  modport source (output valid, point_x, point_y, octant, last, input ready);
  modport sink   (input valid, point_x, point_y, octant, last, output ready);
endinterface
`default_nettype wire

// ----- sv/midpoint_circle_generator_unit.sv -----
// Start item: the front end squares, sums, takes the root one bit pair per cycle,
// rounds and pushes the command to the queue; it takes no new item until that push
// is done. A step item goes straight to the push.
// Each emitting item then gives eight points, one per cycle while the sink is ready;
// the back end takes a new command only while idle. A two-entry queue decouples them.
// Reset (async, active low) clears all control: idle, no circle in progress.
`default_nettype none
module midpoint_circle_generator_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mcg_in_if.sink    item_i,
  mcg_out_if.source point_o
);
  import mcg_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  mcg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  mcg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  mcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .point_o     (point_o)
  );

endmodule
`default_nettype wire

// ----- sv/mcg_front.sv -----
`default_nettype none
module mcg_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  mcg_in_if.sink             item_i,
  output mcg_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i
);
  import mcg_pkg::*;

  front_state_e state_q, state_d;
  cmd_t         cmd_q;
  coord_t       adx_q, ady_q;
  coord_t       adx_d, ady_d;
  logic [SQ_BITS-1:0]   sqx_q, sqy_q;
  logic [ROOT_BITS-1:0] rem_q, root_q, bit_q;
  logic [ROOT_BITS-1:0] trial, rnd;
  logic [ITER_BITS-1:0] iter_q;
  ofs_t                 radius_d;

  assign adx_d = (item_i.rim_x >= item_i.center_x) ? item_i.rim_x - item_i.center_x
                                                   : item_i.center_x - item_i.rim_x;
  assign ady_d = (item_i.rim_y >= item_i.center_y) ? item_i.rim_y - item_i.center_y
                                                   : item_i.center_y - item_i.rim_y;

  assign trial = root_q + bit_q;
  // round to nearest: remainder above root means n >= r*r + r + 1
  assign rnd   = root_q + ROOT_BITS'(rem_q > root_q);

  always_comb begin
    if (rnd > ROOT_BITS'(RADIUS_MAX)) begin
      radius_d = ofs_t'(RADIUS_MAX);
    end else begin
      radius_d = rnd[OFS_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: begin
        if (item_i.valid) begin
          state_d = (op_e'(item_i.operation) == OP_START) ? FE_SQUARE : FE_PUSH;
        end
      end
      FE_SQUARE: state_d = FE_SUM;
      FE_SUM:    state_d = FE_ROOT;
      FE_ROOT: begin
        if (iter_q == ITER_BITS'(ROOT_ITERS - 1)) begin
          state_d = FE_ROUND;
        end
      end
      FE_ROUND:  state_d = FE_PUSH;
      FE_PUSH: begin
        if (cmd_ready_i) begin
          state_d = FE_IDLE;
        end
      end
      default:   state_d = FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_i.ready = (state_q == FE_IDLE);
    cmd_valid_o  = (state_q == FE_PUSH);
    cmd_o        = cmd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture, squares, sum, digit-by-digit square root (one bit pair per cycle), rounding
  always_ff @(posedge clk_i) begin
    case (state_q)
      FE_IDLE: begin
        if (item_i.valid) begin
          cmd_q.op     <= op_e'(item_i.operation);
          cmd_q.cx     <= item_i.center_x;
          cmd_q.cy     <= item_i.center_y;
          cmd_q.radius <= '0;
          adx_q        <= adx_d;
          ady_q        <= ady_d;
        end
      end
      FE_SQUARE: begin
        sqx_q <= {{COORD_BITS{1'b0}}, adx_q} * {{COORD_BITS{1'b0}}, adx_q};
        sqy_q <= {{COORD_BITS{1'b0}}, ady_q} * {{COORD_BITS{1'b0}}, ady_q};
      end
      FE_SUM: begin
        rem_q  <= ROOT_BITS'(sqx_q) + ROOT_BITS'(sqy_q);
        root_q <= '0;
        bit_q  <= ROOT_BITS'(1) << (2 * COORD_BITS);
        iter_q <= '0;
      end
      FE_ROOT: begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q  <= bit_q >> 2;
        iter_q <= iter_q + ITER_BITS'(1);
      end
      FE_ROUND: cmd_q.radius <= radius_d;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/mcg_queue.sv -----
`default_nettype none
module mcg_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mcg_pkg::cmd_t push_data_i,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  output mcg_pkg::cmd_t      pop_data_o,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i
);
  import mcg_pkg::*;

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic                push, pop;

  assign push_ready_o = (count_q != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_BITS'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mcg_back.sv -----
`default_nettype none
module mcg_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mcg_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  mcg_out_if.source          point_o
);
  import mcg_pkg::*;

  back_state_e state_q, state_d;
  logic        active_q;
  logic        final_q;
  oct_t        k_q;
  coord_t      cx_q, cy_q;
  ofs_t        a_q, b_q;
  dec_t        d_q;
  logic        out_valid_q;
  pt_t         px_q, py_q;
  oct_t        oct_q;
  logic        last_q;

  logic        take, load_out;
  ofs_t        a_new, b_new;
  dec_t        d_new, d_start;
  logic        step_final;
  logic [PT_BITS-1:0] cx12, cy12;
  logic [PT_BITS-1:0] xap, xam, xbp, xbm, yap, yam, ybp, ybm;
  logic [PT_BITS-1:0] px_d, py_d;

  // octant step
  always_comb begin
    a_new = a_q + ofs_t'(1);
    if (d_q > 0) begin
      b_new = b_q - ofs_t'(1);
      d_new = d_q + ((ofs_to_dec(a_new) - ofs_to_dec(b_new)) <<< 2) + DEC_INC_DIAG;
    end else begin
      b_new = b_q;
      d_new = d_q + (ofs_to_dec(a_new) <<< 2) + DEC_INC_AXIS;
    end
    step_final = (b_new < a_new);
    d_start    = DEC_INIT - (ofs_to_dec(cmd_i.radius) <<< 1);
  end

  // mirrored points, all arithmetic modulo the point width
  always_comb begin
    cx12 = to_pt(cx_q);
    cy12 = to_pt(cy_q);
    xap  = cx12 + $unsigned(a_q);
    xam  = cx12 - $unsigned(a_q);
    xbp  = cx12 + $unsigned(b_q);
    xbm  = cx12 - $unsigned(b_q);
    yap  = cy12 + $unsigned(a_q);
    yam  = cy12 - $unsigned(a_q);
    ybp  = cy12 + $unsigned(b_q);
    ybm  = cy12 - $unsigned(b_q);
    case (k_q)
      3'd0:    begin px_d = xap; py_d = ybp; end
      3'd1:    begin px_d = xam; py_d = ybp; end
      3'd2:    begin px_d = xap; py_d = ybm; end
      3'd3:    begin px_d = xam; py_d = ybm; end
      3'd4:    begin px_d = xbp; py_d = yap; end
      3'd5:    begin px_d = xbm; py_d = yap; end
      3'd6:    begin px_d = xbp; py_d = yam; end
      default: begin px_d = xbm; py_d = yam; end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == OP_START || active_q)) begin
          state_d = BE_EMIT;
        end
      end
      BE_EMIT: begin
        if (load_out && k_q == LAST_OCTANT) begin
          state_d = BE_IDLE;
        end
      end
      default: state_d = BE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready_o     = (state_q == BE_IDLE);
    take            = cmd_valid_i && (state_q == BE_IDLE);
    load_out        = (state_q == BE_EMIT) && (!out_valid_q || point_o.ready);
    point_o.valid   = out_valid_q;
    point_o.point_x = px_q;
    point_o.point_y = py_q;
    point_o.octant  = oct_q;
    point_o.last    = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      active_q    <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        k_q <= '0;
        if (cmd_i.op == OP_START) begin
          active_q <= 1'b1;
        end else if (step_final) begin
          active_q <= 1'b0;
        end
      end else if (load_out) begin
        k_q <= k_q + oct_t'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (point_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (cmd_i.op == OP_START) begin
        cx_q    <= cmd_i.cx;
        cy_q    <= cmd_i.cy;
        a_q     <= '0;
        b_q     <= cmd_i.radius;
        d_q     <= d_start;
        final_q <= 1'b0;
      end else if (active_q) begin
        a_q     <= a_new;
        b_q     <= b_new;
        d_q     <= d_new;
        final_q <= step_final;
      end
    end
    if (load_out) begin
      px_q   <= px_d;
      py_q   <= py_d;
      oct_q  <= k_q;
      last_q <= final_q && (k_q == LAST_OCTANT);
    end
  end

endmodule
`default_nettype wire

// ----- sv/mcg_checker.sv -----
`default_nettype none
module mcg_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire mcg_pkg::pt_t   point_x_i,
  input wire mcg_pkg::pt_t   point_y_i,
  input wire mcg_pkg::oct_t  octant_i,
  input wire logic           last_i
);
  import mcg_pkg::*;

  // stalled point holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("point valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({point_x_i, point_y_i, octant_i, last_i}))
    else $error("point payload changed while stalled");

  // end of circle only on the final mirrored position
  a_last_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> octant_i == LAST_OCTANT)
    else $error("last marked on a point other than octant 7");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_i)
    else $error("point valid right after reset");

endmodule

bind midpoint_circle_generator_unit mcg_checker u_mcg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (point_o.valid),
  .out_ready_i (point_o.ready),
  .point_x_i   (point_o.point_x),
  .point_y_i   (point_o.point_y),
  .octant_i    (point_o.octant),
  .last_i      (point_o.last)
);
`default_nettype wire
